// ----- sv/tspb_pkg.sv -----
// shared types, constants and helpers for the tagged slot packet buffer
// no dependencies; imported by every module of the block but the ram
package tspb_pkg;

    localparam int SLOT_COUNT   = 4;
    localparam int PACKET_BYTES = 64;

    localparam int TAG_W   = 4;
    localparam int EP_W    = 3;
    localparam int DIR_BIT = 3;
    localparam int BYTE_W  = 8;
    localparam logic [BYTE_W-1:0] BYTE_MASK = 8'hFF;

    localparam int CNT_W   = $clog2(PACKET_BYTES + 1);
    localparam int SLOT_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int MEM_DEPTH = SLOT_COUNT * PACKET_BYTES;
    localparam int ADDR_W  = $clog2(MEM_DEPTH);

    typedef logic [TAG_W-1:0]  tag_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [BYTE_W-1:0] byte_t;

    typedef enum logic [1:0] {
        REQ_PUSH  = 2'd0,
        REQ_PULL  = 2'd1,
        REQ_QUERY = 2'd2
    } req_e;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_STREAM
    } state_e;

    // outcome of one slot lookup
    typedef struct packed {
        logic  found;
        slot_t slot;
        cnt_t  fill;
        cnt_t  read_pos;
    } pick_t;

    // write-back of one slot's descriptor
    typedef struct packed {
        logic  en;
        slot_t slot;
        tag_t  tag;
        cnt_t  fill;
        cnt_t  read_pos;
    } slot_upd_t;

    // one result, read_byte comes from the byte memory when from_ram is set
    typedef struct packed {
        logic is_last;
        logic nothing_read;
        logic push_accepted;
        logic from_ram;
        cnt_t readable;
        cnt_t writable;
    } res_t;

    function automatic tag_t make_tag(input logic dir, input logic [EP_W-1:0] ep);
        tag_t t;
        t = '0;
        t[DIR_BIT] = dir;
        t[EP_W-1:0] = ep;
        return t;
    endfunction

    function automatic addr_t byte_addr(input slot_t slot, input cnt_t pos);
        return addr_t'(addr_t'(slot) * addr_t'(PACKET_BYTES)) + addr_t'(pos);
    endfunction

endpackage

// ----- sv/tspb_ram.sv -----
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module tspb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- sv/tspb_slot_table.sv -----
// slot descriptors (tag, fill, read position) and the slot lookup
// depends on tspb_pkg
module tspb_slot_table (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [tspb_pkg::EP_W-1:0]  endpoint,
    input  tspb_pkg::slot_upd_t        upd,
    output tspb_pkg::pick_t            pick_out,
    output tspb_pkg::pick_t            pick_in
);
    import tspb_pkg::*;

    tag_t tag_reg      [SLOT_COUNT];
    cnt_t fill_reg     [SLOT_COUNT];
    cnt_t read_pos_reg [SLOT_COUNT];

    pick_t pick [2];

    // last matching tag wins, otherwise the lowest empty slot
    always_comb
    begin
        tag_t  key;
        logic  hit;
        logic  empty;
        slot_t hit_idx;
        slot_t empty_idx;
        for (int k = 0; k < 2; k++)
        begin
            key       = make_tag(k[0], endpoint);
            hit       = 1'b0;
            empty     = 1'b0;
            hit_idx   = '0;
            empty_idx = '0;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                if (tag_reg[i] == key)
                begin
                    hit     = 1'b1;
                    hit_idx = slot_t'(i);
                end
            end
            for (int i = SLOT_COUNT - 1; i >= 0; i--)
            begin
                if (fill_reg[i] == '0)
                begin
                    empty     = 1'b1;
                    empty_idx = slot_t'(i);
                end
            end
            pick[k].found    = hit | empty;
            pick[k].slot     = hit ? hit_idx : empty_idx;
            pick[k].fill     = fill_reg[pick[k].slot];
            pick[k].read_pos = read_pos_reg[pick[k].slot];
        end
    end

    assign pick_out = pick[0];
    assign pick_in  = pick[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                tag_reg[i]      <= '0;
                fill_reg[i]     <= '0;
                read_pos_reg[i] <= '0;
            end
        end
        else if (upd.en)
        begin
            tag_reg[upd.slot]      <= upd.tag;
            fill_reg[upd.slot]     <= upd.fill;
            read_pos_reg[upd.slot] <= upd.read_pos;
        end
    end

endmodule

// ----- sv/tagged_slot_packet_buffer.sv -----
// A push or a query is taken while busy is low; busy stays high for one execute cycle and the
// result strobe (valid) comes on the cycle after that, when a new transaction may already be
// taken. A pull keeps busy high through its execute state and one stream state per byte, and
// delivers its bytes on consecutive cycles, one per cycle through the single read port of the
// byte memory, each registered after its stream state; a pull that finds nothing gives one
// registered result from its execute state. An unused request code gives no result.
// Results are shown for one cycle only and cannot be held off, so the receiver must
// take every cycle on which valid is high.
//
// top level: sequencer, descriptor table and byte memory; depends on tspb_pkg,
// tspb_slot_table and tspb_ram
module tagged_slot_packet_buffer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   req_type,
    input  logic [tspb_pkg::EP_W-1:0]    endpoint,
    input  logic                         direction,
    input  tspb_pkg::byte_t              push_byte,
    input  tspb_pkg::cnt_t               pull_count,
    output logic                         valid,
    output tspb_pkg::byte_t              read_byte,
    output logic                         is_last,
    output logic                         nothing_read,
    output logic                         push_accepted,
    output tspb_pkg::cnt_t               readable_bytes,
    output tspb_pkg::cnt_t               writable_room
);
    import tspb_pkg::*;

    state_e state_reg, state_next;

    logic [1:0]       req_reg;
    logic [EP_W-1:0]  ep_reg;
    logic             dir_reg;
    byte_t            data_reg;
    cnt_t             count_reg;

    slot_t slot_reg, slot_next;
    cnt_t  pos_reg, pos_next;
    cnt_t  left_reg, left_next;

    logic valid_reg, valid_next;
    res_t res_reg, res_next;

    pick_t     pick_out, pick_in, sel;
    slot_upd_t upd;

    logic  mem_we, mem_re;
    addr_t mem_waddr, mem_raddr;
    byte_t mem_rdata;

    cnt_t avail;
    cnt_t n_bytes;
    cnt_t new_pos;

    tspb_slot_table u_slots (
        .clk      (clk),
        .rst_n    (rst_n),
        .endpoint (ep_reg),
        .upd      (upd),
        .pick_out (pick_out),
        .pick_in  (pick_in)
    );

    tspb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MEM_DEPTH)
    ) u_bytes (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (data_reg),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign busy = (state_reg != ST_IDLE);
    assign sel  = dir_reg ? pick_in : pick_out;

    assign avail   = sel.fill - sel.read_pos;
    assign n_bytes = (count_reg == '0) ? sel.fill :
                     ((count_reg < avail) ? count_reg : avail);
    assign new_pos = sel.read_pos + n_bytes;

    always_comb
    begin
        state_next = state_reg;
        slot_next  = slot_reg;
        pos_next   = pos_reg;
        left_next  = left_reg;
        valid_next = 1'b0;
        res_next   = '0;
        upd        = '0;
        mem_we     = 1'b0;
        mem_waddr  = byte_addr(sel.slot, sel.fill);
        mem_re     = 1'b0;
        mem_raddr  = byte_addr(slot_reg, pos_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                state_next = ST_IDLE;
                case (req_reg)
                    REQ_PUSH:
                    begin
                        valid_next       = 1'b1;
                        res_next.is_last = 1'b1;
                        if (sel.found)
                        begin
                            upd.en       = 1'b1;
                            upd.slot     = sel.slot;
                            upd.tag      = make_tag(dir_reg, ep_reg);
                            upd.fill     = sel.fill;
                            upd.read_pos = sel.read_pos;
                            if (sel.fill < cnt_t'(PACKET_BYTES))
                            begin
                                mem_we                 = 1'b1;
                                upd.fill               = sel.fill + cnt_t'(1);
                                res_next.push_accepted = 1'b1;
                            end
                        end
                    end

                    REQ_PULL:
                    begin
                        if (!sel.found || sel.fill == '0)
                        begin
                            valid_next            = 1'b1;
                            res_next.is_last      = 1'b1;
                            res_next.nothing_read = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_STREAM;
                            slot_next  = sel.slot;
                            left_next  = n_bytes;
                            upd.en     = 1'b1;
                            upd.slot   = sel.slot;
                            upd.tag    = make_tag(dir_reg, ep_reg);
                            if (count_reg == '0)
                            begin
                                pos_next     = '0;
                                upd.fill     = '0;
                                upd.read_pos = '0;
                            end
                            else
                            begin
                                pos_next = sel.read_pos;
                                // drained slot starts over
                                if (new_pos >= sel.fill)
                                begin
                                    upd.fill     = '0;
                                    upd.read_pos = '0;
                                end
                                else
                                begin
                                    upd.fill     = sel.fill;
                                    upd.read_pos = new_pos;
                                end
                            end
                        end
                    end

                    REQ_QUERY:
                    begin
                        valid_next       = 1'b1;
                        res_next.is_last = 1'b1;
                        if (pick_in.found)
                        begin
                            res_next.readable = pick_in.fill - pick_in.read_pos;
                        end
                        if (pick_out.found)
                        begin
                            res_next.writable = cnt_t'(PACKET_BYTES) - pick_out.fill;
                        end
                    end

                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            ST_STREAM:
            begin
                // byte arrives from the memory in the cycle after the read
                mem_re            = 1'b1;
                valid_next        = 1'b1;
                res_next.from_ram = 1'b1;
                pos_next          = pos_reg + cnt_t'(1);
                left_next         = left_reg - cnt_t'(1);
                if (left_reg == cnt_t'(1))
                begin
                    res_next.is_last = 1'b1;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            res_reg   <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            req_reg   <= req_type;
            ep_reg    <= endpoint;
            dir_reg   <= direction;
            data_reg  <= push_byte & BYTE_MASK;
            count_reg <= pull_count;
        end
        slot_reg <= slot_next;
        pos_reg  <= pos_next;
        left_reg <= left_next;
    end

    assign valid          = valid_reg;
    assign read_byte      = res_reg.from_ram ? mem_rdata : '0;
    assign is_last        = res_reg.is_last;
    assign nothing_read   = res_reg.nothing_read;
    assign push_accepted  = res_reg.push_accepted;
    assign readable_bytes = res_reg.readable;
    assign writable_room  = res_reg.writable;

endmodule

// ----- bench/tagged_slot_packet_buffer_tb.sv -----
// self-checking bench for the tagged slot packet buffer: directed and random transactions
// checked against a behavioural slot/byte model kept in the bench
// depends on tspb_pkg and tagged_slot_packet_buffer
module tagged_slot_packet_buffer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tspb_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 250;
    localparam int DRAIN_CYCLES = 100;

    typedef struct {
        logic [1:0]      kind;
        logic [EP_W-1:0] ep;
        logic            dir;
        byte_t           data;
        cnt_t            count;
    } request_t;

    typedef struct {
        byte_t byte_out;
        logic  last;
        logic  empty;
        logic  stored;
        cnt_t  readable;
        cnt_t  room;
    } outcome_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            start = 1'b0;
    logic            busy;
    logic [1:0]      req_type = 2'd0;
    logic [EP_W-1:0] endpoint = '0;
    logic            direction = 1'b0;
    byte_t           push_byte = '0;
    cnt_t            pull_count = '0;
    logic            valid;
    byte_t           read_byte;
    logic            is_last;
    logic            nothing_read;
    logic            push_accepted;
    cnt_t            readable_bytes;
    cnt_t            writable_room;

    // bench copy of the slot descriptors and byte store
    tag_t     tag_of [SLOT_COUNT];
    int       fill_of [SLOT_COUNT];
    int       rdpos_of [SLOT_COUNT];
    byte_t    bytes_of [SLOT_COUNT][PACKET_BYTES];

    request_t request_q [$];
    outcome_t due_outcomes [$];
    int       counted_items = 0;
    int       errors = 0;
    logic     took = 1'b0;
    int       gap_left = 0;
    int       steady_left = 0;

    tagged_slot_packet_buffer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .req_type       (req_type),
        .endpoint       (endpoint),
        .direction      (direction),
        .push_byte      (push_byte),
        .pull_count     (pull_count),
        .valid          (valid),
        .read_byte      (read_byte),
        .is_last        (is_last),
        .nothing_read   (nothing_read),
        .push_accepted  (push_accepted),
        .readable_bytes (readable_bytes),
        .writable_room  (writable_room)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // last slot with a matching tag, else first empty slot, else none
    function automatic int pick_slot(input logic [EP_W-1:0] ep, input logic dir);
        tag_t want;
        int   hit;
        want = {dir, ep};
        hit = -1;
        for (int i = 0; i < SLOT_COUNT; i++)
            if (tag_of[i] == want)
                hit = i;
        if (hit < 0)
        begin
            for (int i = SLOT_COUNT - 1; i >= 0; i--)
                if (fill_of[i] == 0)
                    hit = i;
        end
        return hit;
    endfunction

    task automatic apply_request(input request_t rq);
        outcome_t o;
        int       s;
        int       n;
        int       first;
        int       avail;
        o = '{byte_out: '0, last: 1'b1, empty: 1'b0, stored: 1'b0, readable: '0, room: '0};
        if (rq.kind == REQ_PUSH)
        begin
            s = pick_slot(rq.ep, rq.dir);
            if (s >= 0)
            begin
                if (fill_of[s] < PACKET_BYTES)
                begin
                    bytes_of[s][fill_of[s]] = rq.data;
                    fill_of[s]++;
                    o.stored = 1'b1;
                end
                tag_of[s] = {rq.dir, rq.ep};
            end
            due_outcomes.push_back(o);
        end
        else if (rq.kind == REQ_PULL)
        begin
            s = pick_slot(rq.ep, rq.dir);
            if (s < 0 || fill_of[s] == 0)
            begin
                o.empty = 1'b1;
                due_outcomes.push_back(o);
            end
            else
            begin
                if (rq.count == 0)
                begin
                    // whole slot from the start, read position included
                    first = 0;
                    n = fill_of[s];
                    fill_of[s] = 0;
                    rdpos_of[s] = 0;
                end
                else
                begin
                    avail = fill_of[s] - rdpos_of[s];
                    n = (int'(rq.count) < avail) ? int'(rq.count) : avail;
                    first = rdpos_of[s];
                    rdpos_of[s] = first + n;
                    if (rdpos_of[s] >= fill_of[s])
                    begin
                        rdpos_of[s] = 0;
                        fill_of[s] = 0;
                    end
                end
                for (int i = 0; i < n; i++)
                begin
                    o.byte_out = bytes_of[s][(first + i) % PACKET_BYTES];
                    o.last = (i == n - 1);
                    due_outcomes.push_back(o);
                end
                tag_of[s] = {rq.dir, rq.ep};
            end
        end
        else if (rq.kind == REQ_QUERY)
        begin
            s = pick_slot(rq.ep, 1'b1);
            if (s >= 0)
                o.readable = cnt_t'(fill_of[s] - rdpos_of[s]);
            s = pick_slot(rq.ep, 1'b0);
            if (s >= 0)
                o.room = cnt_t'(PACKET_BYTES - fill_of[s]);
            due_outcomes.push_back(o);
        end
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endtask

    // monitor: check results and predict on each accepted transaction
    always @(posedge clk)
    begin
        outcome_t want;
        request_t rq;
        took = 1'b0;
        if (rst_n)
        begin
            if (valid === 1'b1)
            begin
                if (due_outcomes.size() == 0)
                begin
                    $error("result with nothing expected: read_byte %0d", read_byte);
                    errors++;
                end
                else
                begin
                    want = due_outcomes.pop_front();
                    compare_field("read_byte", want.byte_out, read_byte);
                    compare_field("is_last", 8'(want.last), 8'(is_last));
                    compare_field("nothing_read", 8'(want.empty), 8'(nothing_read));
                    compare_field("push_accepted", 8'(want.stored), 8'(push_accepted));
                    compare_field("readable_bytes", 8'(want.readable), 8'(readable_bytes));
                    compare_field("writable_room", 8'(want.room), 8'(writable_room));
                end
            end
            if (start === 1'b1 && busy === 1'b0)
            begin
                took = 1'b1;
                rq.kind = req_type;
                rq.ep = endpoint;
                rq.dir = direction;
                rq.data = push_byte;
                rq.count = pull_count;
                apply_request(rq);
            end
        end
    end

    // driver: one transaction at a time from the queue, random gaps in between
    always @(negedge clk)
    begin
        request_t nx;
        logic     go;
        int       r;
        if (rst_n)
        begin
            go = start;
            if (start && took)
                go = 1'b0;
            if (!go)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (request_q.size() > 0)
                begin
                    nx = request_q.pop_front();
                    req_type <= nx.kind;
                    endpoint <= nx.ep;
                    direction <= nx.dir;
                    push_byte <= nx.data;
                    pull_count <= nx.count;
                    go = 1'b1;
                    r = $urandom_range(0, 99);
                    if (steady_left > 0)
                    begin
                        steady_left--;
                        gap_left = 0;
                    end
                    else if (r < 4)
                    begin
                        steady_left = $urandom_range(15, 40);
                        gap_left = 0;
                    end
                    else if (r < 55)
                        gap_left = 0;
                    else if (r < 90)
                        gap_left = $urandom_range(1, 3);
                    else
                        gap_left = $urandom_range(8, 30);
                end
            end
            start <= go;
        end
    end

    function automatic void enqueue(input logic [1:0] kind, input logic [EP_W-1:0] ep,
                                    input logic dir, input byte_t data, input cnt_t count);
        request_t rq;
        rq.kind = kind;
        rq.ep = ep;
        rq.dir = dir;
        rq.data = data;
        rq.count = count;
        request_q.push_back(rq);
        if (kind != REQ_UNUSED)
            counted_items++;
    endfunction

    initial
    begin
        int          r;
        int          n;
        logic [EP_W-1:0] ep;
        logic        dir;
        cnt_t        cnt;

        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            tag_of[i] = '0;
            fill_of[i] = 0;
            rdpos_of[i] = 0;
        end

        // directed: byte extremes, whole and partial pulls, empty pull, unused code,
        // all slots taken so that a push and a pull find no slot
        enqueue(REQ_PUSH, 3'd0, 1'b0, 8'h00, 7'd0);
        enqueue(REQ_PUSH, 3'd0, 1'b0, 8'hFF, 7'd127);
        enqueue(REQ_QUERY, 3'd0, 1'b1, 8'h00, 7'd0);
        enqueue(REQ_PULL, 3'd0, 1'b0, 8'h00, 7'd0);
        enqueue(REQ_PULL, 3'd0, 1'b0, 8'hFF, 7'd5);
        enqueue(REQ_PUSH, 3'd7, 1'b1, 8'hA5, 7'd0);
        enqueue(REQ_PUSH, 3'd7, 1'b1, 8'h5A, 7'd0);
        enqueue(REQ_PUSH, 3'd7, 1'b1, 8'h3C, 7'd0);
        enqueue(REQ_PULL, 3'd7, 1'b1, 8'h00, 7'd1);
        enqueue(REQ_QUERY, 3'd7, 1'b0, 8'h00, 7'd0);
        enqueue(REQ_PULL, 3'd7, 1'b1, 8'h00, 7'd127);
        enqueue(REQ_UNUSED, 3'd5, 1'b1, 8'hC3, 7'd64);
        enqueue(REQ_PUSH, 3'd1, 1'b0, 8'h11, 7'd0);
        enqueue(REQ_PUSH, 3'd2, 1'b1, 8'h22, 7'd0);
        enqueue(REQ_PUSH, 3'd3, 1'b0, 8'h33, 7'd0);
        enqueue(REQ_PUSH, 3'd4, 1'b1, 8'h44, 7'd0);
        enqueue(REQ_PUSH, 3'd5, 1'b0, 8'h55, 7'd0);
        enqueue(REQ_PULL, 3'd6, 1'b1, 8'h00, 7'd3);
        enqueue(REQ_QUERY, 3'd4, 1'b0, 8'h00, 7'd0);
        enqueue(REQ_PULL, 3'd1, 1'b0, 8'h00, 7'd64);
        enqueue(REQ_PULL, 3'd2, 1'b1, 8'h00, 7'd0);
        enqueue(REQ_PULL, 3'd3, 1'b0, 8'h00, 7'd0);
        enqueue(REQ_PULL, 3'd4, 1'b1, 8'h00, 7'd2);

        // random: mostly fill-then-drain sequences on one tag, some noise
        while (counted_items < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 9);
            ep = EP_W'($urandom_range(0, 7));
            dir = 1'($urandom_range(0, 1));
            if (r <= 5)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 68) : $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                    enqueue(REQ_PUSH, ep, dir, byte_t'($urandom_range(0, 255)),
                            cnt_t'($urandom_range(0, 127)));
                if ($urandom_range(0, 1))
                    enqueue(REQ_QUERY, ep, 1'($urandom_range(0, 1)),
                            byte_t'($urandom_range(0, 255)), cnt_t'($urandom_range(0, 127)));
                for (int j = $urandom_range(1, 3); j > 0; j--)
                begin
                    case ($urandom_range(0, 3))
                        0: cnt = '0;
                        1: cnt = cnt_t'($urandom_range(1, 127));
                        default: cnt = cnt_t'($urandom_range(1, n));
                    endcase
                    enqueue(REQ_PULL, ep, dir, byte_t'($urandom_range(0, 255)), cnt);
                end
            end
            else if (r <= 7)
                enqueue(2'($urandom_range(0, 2)), ep, dir, byte_t'($urandom_range(0, 255)),
                        cnt_t'($urandom_range(0, 64)));
            else if (r == 8)
                enqueue(2'($urandom_range(0, 3)), ep, dir, byte_t'($urandom_range(0, 255)),
                        cnt_t'($urandom_range(0, 127)));
            else
                enqueue(REQ_PULL, ep, dir, byte_t'($urandom_range(0, 255)), 7'd0);
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (request_q.size() > 0 || start)
            @(posedge clk);
        while (due_outcomes.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
